// ===== sv/fpms_pkg.sv =====
// Shared constants, register indexes and the case-folding helper function of the fuzzy path match scorer.
package fpms_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int PATH_MAX_DEF    = 1024;

    localparam int CHAR_W       = 8;
    localparam int CFG_LEN_W    = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int CHARS_PER_WORD = CFG_DATA_W / CHAR_W;
    localparam int SCORE_W      = 11;
    localparam int S_DATA_W     = 8;
    localparam int M_DATA_W     = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CHAR_W-1:0]      char_t;

    localparam cfg_index_t CFG_PATTERN_LENGTH = 2'd0;
    localparam cfg_index_t CFG_CHARS_LOW      = 2'd1;
    localparam cfg_index_t CFG_CHARS_HIGH     = 2'd2;

    localparam char_t CHAR_SLASH = 8'h2F;
    localparam char_t CHAR_UPPER_A = 8'h41;
    localparam char_t CHAR_UPPER_Z = 8'h5A;
    localparam char_t CASE_OFFSET = 8'h20;

    localparam int SCORE_SUBSTRING   = 100;
    localparam int SCORE_AFTER_SLASH = 50;
    localparam int SCORE_PER_CHAR    = 10;
    localparam int SCORE_NONE        = -1;
    localparam int SCORE_MIN         = -1024;
    localparam int SCORE_MAX         = 1023;

    // ASCII-only case folding: A-Z become a-z, every other byte is kept.
    function automatic char_t fold_case(input char_t c);
        char_t r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== sv/fuzzy_path_match_scorer_unit.sv =====
// Top level of the fuzzy path match scorer: streams path bytes and scores them against a pattern.
//
// Usage: the path is streamed one byte per item on the s_ channel, first byte first, with
// s_tlast marking its final byte. Exactly one result item leaves on the m_ channel per path,
// carrying the score (signed, -1 means no match) and a flag that the path was longer than
// PATH_MAX bytes. The pattern is loaded through the cfg_ write port while the block is idle;
// the pattern bytes are case-folded as they are written.
// A result passes from the input register to the result register, which drives m_tvalid,
// once the result register is free to take it.
// Throughput: one byte per cycle while the result register is free for each final byte. An input
// register feeds combinational compare logic (all pattern positions in parallel) that updates the
// per-path state and loads the result register.
// Reset (aresetn low, synchronous) clears the pattern, the per-path state and both valid flags.
// When the receiver stalls, the result waits in the output register; bytes of the next path
// keep flowing, and the input stops only when a second final byte has to wait for that slot.
module fuzzy_path_match_scorer_unit
    import fpms_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int PATH_MAX    = PATH_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // [7:0] path_char
    input  logic                   s_tlast,   // path_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata    // [10:0] score, [11] too_long, [15:12] zero
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = $clog2(PATH_MAX + 1);
    localparam int SW = ((CW > CHAR_W) ? CW : CHAR_W) + 2;
    localparam int EW = (SW > SCORE_W) ? SW : SCORE_W;

    // Configuration.
    logic [CFG_LEN_W-1:0] pattern_length_reg;
    char_t                pattern_reg [PATTERN_MAX];

    // Input register.
    logic  in_valid_reg;
    char_t in_char_reg;
    logic  in_last_reg;

    // Per-path state.
    logic [PATTERN_MAX-1:0] smv_reg;
    logic                   found_reg;
    logic [CW-1:0]          start_reg;
    logic [LW-1:0]          progress_reg;
    logic [CW-1:0]          slash_reg;
    logic [CW-1:0]          count_reg;
    logic                   overflow_reg;

    // Result register.
    logic                      m_valid_reg;
    logic signed [SCORE_W-1:0] m_score_reg;
    logic                      m_too_long_reg;

    logic [PATTERN_MAX-1:0] smv_next;
    logic                   found_next;
    logic [CW-1:0]          start_next;
    logic [LW-1:0]          progress_next;
    logic [CW-1:0]          slash_next;
    logic [CW-1:0]          count_next;
    logic                   overflow_next;

    logic [LW-1:0]          eff_len;
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX:0]   smv_shift;
    logic                   take;
    logic                   hit_full;
    logic                   hit_seq;
    logic                   out_free;
    logic                   advance;
    logic signed [SW-1:0]   score_w;
    logic signed [EW-1:0]   score_ext;
    logic signed [SCORE_W-1:0] score_sat;

    assign eff_len = (pattern_length_reg > CFG_LEN_W'(PATTERN_MAX))
                   ? LW'(PATTERN_MAX) : LW'(pattern_length_reg);

    // The result slot is needed only by a final byte.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            eq[i] = (LW'(i) < eff_len) && (pattern_reg[i] == in_char_reg);
        end
        smv_shift = {smv_reg, 1'b1};
        hit_full  = 1'b0;
        hit_seq   = 1'b0;
        take      = (count_reg != CW'(PATH_MAX));

        smv_next      = smv_reg;
        found_next    = found_reg;
        start_next    = start_reg;
        progress_next = progress_reg;
        slash_next    = slash_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;

        if (!take) begin
            overflow_next = 1'b1;
        end else begin
            if (eff_len != '0) begin
                smv_next = smv_shift[PATTERN_MAX-1:0] & eq;
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    if (eff_len == LW'(i + 1) && smv_next[i]) begin
                        hit_full = 1'b1;
                    end
                    if (progress_reg == LW'(i) && eq[i]) begin
                        hit_seq = 1'b1;
                    end
                end
                // The match ends at this byte, so it began len - 1 bytes earlier.
                if (!found_reg && hit_full) begin
                    found_next = 1'b1;
                    start_next = count_reg + CW'(1) - CW'(eff_len);
                end
                if (hit_seq) begin
                    progress_next = progress_reg + LW'(1);
                end
            end
            if (in_char_reg == CHAR_SLASH) begin
                slash_next = count_reg + CW'(1);
            end
            count_next = count_reg + CW'(1);
        end
    end

    always_comb begin
        if (eff_len == '0) begin
            score_w = '0;
        end else if (found_next) begin
            if (start_next >= slash_next) begin
                score_w = SW'(SCORE_SUBSTRING + SCORE_AFTER_SLASH)
                        - $signed({1'b0, start_next});
            end else begin
                score_w = SW'(SCORE_SUBSTRING) - $signed({1'b0, start_next});
            end
        end else if (progress_next == eff_len) begin
            score_w = $signed(SW'(eff_len) * SW'(SCORE_PER_CHAR))
                    - $signed({1'b0, count_next});
        end else begin
            score_w = SW'(SCORE_NONE);
        end
        score_ext = EW'(score_w);
        if (score_ext < EW'(SCORE_MIN)) begin
            score_sat = SCORE_W'(SCORE_MIN);
        end else if (score_ext > EW'(SCORE_MAX)) begin
            score_sat = SCORE_W'(SCORE_MAX);
        end else begin
            score_sat = score_ext[SCORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                pattern_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wdata[CFG_LEN_W-1:0];
                end
                CFG_CHARS_LOW: begin
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        if (i < CHARS_PER_WORD) begin
                            pattern_reg[i] <=
                                fold_case(cfg_wdata[CHAR_W*(i % CHARS_PER_WORD) +: CHAR_W]);
                        end
                    end
                end
                CFG_CHARS_HIGH: begin
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        if (i >= CHARS_PER_WORD) begin
                            pattern_reg[i] <=
                                fold_case(cfg_wdata[CHAR_W*(i % CHARS_PER_WORD) +: CHAR_W]);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_char_reg <= fold_case(s_tdata[CHAR_W-1:0]);
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            smv_reg      <= '0;
            found_reg    <= 1'b0;
            start_reg    <= '0;
            progress_reg <= '0;
            slash_reg    <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (advance) begin
            smv_reg      <= smv_next;
            found_reg    <= found_next;
            start_reg    <= start_next;
            progress_reg <= progress_next;
            slash_reg    <= slash_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            m_score_reg    <= score_sat;
            m_too_long_reg <= overflow_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - SCORE_W - 1)'(0), m_too_long_reg, m_score_reg};

endmodule
